### rtl/core/gifl_pkg.sv
// Package for the GIF LZW decoder: field widths, status and function codes,
// controller state type. Used by gif_lzw_decoder_top.
`default_nettype none
package gifl_pkg;
	localparam int MaxCodeBits = 12;
	localparam int DictDepth   = 1 << MaxCodeBits;
	localparam int IdxW        = MaxCodeBits;
	localparam int CntW        = MaxCodeBits + 1;
	localparam int DictW       = IdxW + 8;

	typedef enum logic [1:0] {
		FUNC_PUSH    = 2'd0,
		FUNC_PULL    = 2'd1,
		FUNC_RESTART = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_PIXEL     = 3'd0,
		ST_NEED      = 3'd1,
		ST_STOP      = 3'd2,
		ST_EXHAUSTED = 3'd3,
		ST_BAD       = 3'd4,
		ST_ACCEPT    = 3'd5,
		ST_REFUSE    = 3'd6,
		ST_RESTART   = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RD,
		S_WALK,
		S_LEAF,
		S_POP_W,
		S_EMIT
	} state_t;
endpackage
`default_nettype wire

### rtl/core/gifl_if.sv
// Valid/ready channel interfaces of the GIF LZW decoder (input and result).
// Depends on nothing.
`default_nettype none
interface gifl_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, func, data_byte, last_byte, input ready);
	modport sink (input valid, func, data_byte, last_byte, output ready);
endinterface

interface gifl_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] pixel;
	modport source (output valid, status, pixel, input ready);
	modport sink (input valid, status, pixel, output ready);
endinterface
`default_nettype wire

### rtl/core/gifl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module gifl_ram #(
	parameter int Width = 8,
	parameter int Depth = 4096
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(Depth)-1:0] waddr,
	input  wire [Width-1:0]         wdata,
	input  wire [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]        rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/core/gif_lzw_decoder_top.sv
// GIF LZW decoder top level: bit buffer, code parser, dictionary and
// expansion stack memories. Depends on gifl_pkg, gifl_if and gifl_ram.
//
// Use: each input transaction on in_ch carries a func. A push loads one
// compressed byte into the 24-bit bit buffer, a pull returns the next pixel
// or a status, a restart reinitializes the decoder. Every input transaction
// gives exactly one result transaction on out_ch. cfg_we/cfg_wdata set the
// minimum code size; write it only while the block is idle.
// Push, restart and unknown func are answered from S_IDLE. A pull that
// pops a buffered pixel goes on to S_POP_W, which reads the stack. A pull
// that decodes a new code passes S_DECODE, then S_WALK for each dictionary
// entry on the prefix chain (one dictionary memory read each), then S_LEAF;
// a clear code repeats S_DECODE and a repeated-string code adds S_RD.
// One item is in work at a time. The result register frees the input side:
// a new item is accepted while a finished result waits for out_ch.ready;
// if that item completes before the result is taken, it waits in a holding
// register and the block stops accepting until the output drains.
// Reset clears all control state; the memories are not cleared and entries
// are valid once written.
`default_nettype none
module gif_lzw_decoder_top (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cfg_we,
	input  wire [3:0]       cfg_wdata,
	gifl_in_if.sink         in_ch,
	gifl_out_if.source      out_ch
);
	localparam int IdxW  = gifl_pkg::IdxW;
	localparam int CntW  = gifl_pkg::CntW;
	localparam int DictW = gifl_pkg::DictW;
	localparam logic [CntW-1:0] TableSize = CntW'(gifl_pkg::DictDepth);

	gifl_pkg::state_t state_q, state_d;

	logic [3:0]      min_q;
	logic [CntW-1:0] cnt_q, cnt_d;
	logic [CntW-1:0] nf_q, nf_d;
	logic [3:0]      cw_q, cw_d;
	logic [IdxW-1:0] prev_q, prev_d;
	logic            pv_q, pv_d;
	logic [7:0]      pfirst_q, pfirst_d;
	logic [23:0]     buf_q, buf_d;
	logic [4:0]      bc_q, bc_d;
	logic            last_q, last_d;
	logic            fin_q, fin_d;
	logic [IdxW-1:0] c_q, c_d;
	logic            add_q, add_d;
	logic [IdxW-1:0] add_idx_q, add_idx_d;
	logic [IdxW-1:0] add_pre_q, add_pre_d;

	logic                    out_valid_q;
	gifl_pkg::status_t       out_status_q, pend_status_q;
	logic [7:0]              out_pixel_q, pend_pixel_q;

	logic                    emit;
	gifl_pkg::status_t       emit_status;
	logic [7:0]              emit_pixel;
	logic                    slot_free;

	logic             d_we;
	logic [IdxW-1:0]  d_waddr, d_raddr;
	logic [DictW-1:0] d_wdata, d_rdata;
	logic             s_we;
	logic [IdxW-1:0]  s_waddr, s_raddr;
	logic [7:0]       s_wdata, s_rdata;

	logic [3:0]      eff_min;
	logic [CntW-1:0] clr;
	logic [23:0]     mask;
	logic [IdxW-1:0] code;
	logic [CntW-1:0] code_x;
	logic [IdxW-1:0] w_pre;
	logic [7:0]      w_suf;
	logic [CntW-1:0] nf_inc;
	logic            in_acc;

	gifl_ram #(.Width(DictW), .Depth(gifl_pkg::DictDepth)) u_dict (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata)
	);

	gifl_ram #(.Width(8), .Depth(gifl_pkg::DictDepth)) u_stack (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	always_comb begin
		eff_min = min_q;
		if (min_q < 4'd2) eff_min = 4'd2;
		if (min_q > 4'd8) eff_min = 4'd8;
	end

	assign clr       = CntW'(1) << eff_min;
	assign mask      = (24'd1 << cw_q) - 24'd1;
	assign code      = IdxW'(buf_q & mask);
	assign code_x    = {1'b0, code};
	assign w_pre     = d_rdata[DictW-1:8];
	assign w_suf     = d_rdata[7:0];
	assign nf_inc    = nf_q + CntW'(1);
	assign slot_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == gifl_pkg::S_IDLE);
	assign in_acc    = in_ch.valid && in_ch.ready;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		nf_d      = nf_q;
		cw_d      = cw_q;
		prev_d    = prev_q;
		pv_d      = pv_q;
		pfirst_d  = pfirst_q;
		buf_d     = buf_q;
		bc_d      = bc_q;
		last_d    = last_q;
		fin_d     = fin_q;
		c_d       = c_q;
		add_d     = add_q;
		add_idx_d = add_idx_q;
		add_pre_d = add_pre_q;
		emit        = 1'b0;
		emit_status = gifl_pkg::ST_REFUSE;
		emit_pixel  = 8'd0;
		d_we    = 1'b0;
		d_waddr = add_idx_q;
		d_wdata = {add_pre_q, c_q[7:0]};
		d_raddr = c_q;
		s_we    = 1'b0;
		s_waddr = cnt_q[IdxW-1:0];
		s_wdata = w_suf;
		s_raddr = IdxW'(cnt_q - CntW'(1));

		case (state_q)
			gifl_pkg::S_IDLE: begin
				if (in_acc) begin
					case (gifl_pkg::func_t'(in_ch.func))
						gifl_pkg::FUNC_PUSH: begin
							emit = 1'b1;
							if (!fin_q && !last_q && bc_q <= 5'd16) begin
								buf_d  = buf_q | (24'(in_ch.data_byte) << bc_q);
								bc_d   = bc_q + 5'd8;
								last_d = in_ch.last_byte;
								emit_status = gifl_pkg::ST_ACCEPT;
							end
						end
						gifl_pkg::FUNC_PULL: begin
							if (cnt_q != '0) begin
								cnt_d   = cnt_q - CntW'(1);
								state_d = gifl_pkg::S_POP_W;
							end else begin
								state_d = gifl_pkg::S_DECODE;
							end
						end
						gifl_pkg::FUNC_RESTART: begin
							cw_d   = eff_min + 4'd1;
							nf_d   = clr + CntW'(2);
							pv_d   = 1'b0;
							prev_d = '0;
							cnt_d  = '0;
							buf_d  = '0;
							bc_d   = '0;
							last_d = 1'b0;
							fin_d  = 1'b0;
							emit   = 1'b1;
							emit_status = gifl_pkg::ST_RESTART;
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			gifl_pkg::S_DECODE: begin
				d_raddr = code;
				d_waddr = nf_q[IdxW-1:0];
				d_wdata = {prev_q, pfirst_q};
				if (fin_q) begin
					emit = 1'b1;
					emit_status = gifl_pkg::ST_STOP;
				end else if (bc_q < 5'(cw_q)) begin
					emit = 1'b1;
					emit_status = last_q ? gifl_pkg::ST_EXHAUSTED : gifl_pkg::ST_NEED;
				end else begin
					buf_d = buf_q >> cw_q;
					bc_d  = bc_q - 5'(cw_q);
					if (code_x == clr) begin
						cw_d   = eff_min + 4'd1;
						nf_d   = clr + CntW'(2);
						pv_d   = 1'b0;
						prev_d = '0;
					end else if (code_x == clr + CntW'(1)) begin
						fin_d = 1'b1;
						emit  = 1'b1;
						emit_status = gifl_pkg::ST_STOP;
					end else if (code_x > nf_q ||
						(code_x == nf_q && (!pv_q || nf_q >= TableSize))) begin
						emit = 1'b1;
						emit_status = gifl_pkg::ST_BAD;
					end else begin
						add_d     = pv_q && nf_q < TableSize;
						add_idx_d = nf_q[IdxW-1:0];
						add_pre_d = prev_q;
						if (pv_q && nf_q < TableSize) begin
							nf_d = nf_inc;
							if (nf_inc == (CntW'(1) << cw_q) && cw_q < 4'(gifl_pkg::MaxCodeBits))
								cw_d = cw_q + 4'd1;
						end
						prev_d = code;
						pv_d   = 1'b1;
						c_d    = code;
						if (code_x < clr) begin
							state_d = gifl_pkg::S_LEAF;
						end else if (code_x == nf_q) begin
							// Repeated string: the entry is written now with the
							// previous string's first pixel, then read back.
							d_we    = 1'b1;
							add_d   = 1'b0;
							state_d = gifl_pkg::S_RD;
						end else begin
							state_d = gifl_pkg::S_WALK;
						end
					end
				end
			end
			gifl_pkg::S_RD: begin
				state_d = gifl_pkg::S_WALK;
			end
			gifl_pkg::S_WALK: begin
				// Read data is the entry of c_q; push its suffix and follow the prefix.
				if (cnt_q < TableSize) begin
					s_we  = 1'b1;
					cnt_d = cnt_q + CntW'(1);
				end
				c_d     = w_pre;
				d_raddr = w_pre;
				if (!({1'b0, w_pre} >= clr && cnt_q + CntW'(1) < TableSize))
					state_d = gifl_pkg::S_LEAF;
			end
			gifl_pkg::S_LEAF: begin
				pfirst_d = c_q[7:0];
				d_we     = add_q;
				add_d    = 1'b0;
				if ({1'b0, c_q} < clr && cnt_q < TableSize) begin
					// The leaf is the top of the stack: hand it out directly.
					emit       = 1'b1;
					emit_status = gifl_pkg::ST_PIXEL;
					emit_pixel = c_q[7:0];
				end else begin
					cnt_d   = cnt_q - CntW'(1);
					state_d = gifl_pkg::S_POP_W;
				end
			end
			gifl_pkg::S_POP_W: begin
				emit       = 1'b1;
				emit_status = gifl_pkg::ST_PIXEL;
				emit_pixel = s_rdata;
			end
			gifl_pkg::S_EMIT: begin
				if (slot_free) state_d = gifl_pkg::S_IDLE;
			end
			default: begin
				state_d = gifl_pkg::S_IDLE;
			end
		endcase

		if (emit) state_d = slot_free ? gifl_pkg::S_IDLE : gifl_pkg::S_EMIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gifl_pkg::S_IDLE;
			min_q       <= 4'd8;
			cnt_q       <= '0;
			nf_q        <= CntW'(258);
			cw_q        <= 4'd9;
			prev_q      <= '0;
			pv_q        <= 1'b0;
			buf_q       <= '0;
			bc_q        <= '0;
			last_q      <= 1'b0;
			fin_q       <= 1'b0;
			add_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) min_q <= cfg_wdata;
			cnt_q  <= cnt_d;
			nf_q   <= nf_d;
			cw_q   <= cw_d;
			prev_q <= prev_d;
			pv_q   <= pv_d;
			buf_q  <= buf_d;
			bc_q   <= bc_d;
			last_q <= last_d;
			fin_q  <= fin_d;
			add_q  <= add_d;
			if ((emit || state_q == gifl_pkg::S_EMIT) && slot_free)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		pfirst_q  <= pfirst_d;
		c_q       <= c_d;
		add_idx_q <= add_idx_d;
		add_pre_q <= add_pre_d;
		if (emit) begin
			pend_status_q <= emit_status;
			pend_pixel_q  <= emit_pixel;
		end
		if (emit && slot_free) begin
			out_status_q <= emit_status;
			out_pixel_q  <= emit_pixel;
		end else if (state_q == gifl_pkg::S_EMIT && slot_free) begin
			out_status_q <= pend_status_q;
			out_pixel_q  <= pend_pixel_q;
		end
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.status = out_status_q;
	assign out_ch.pixel  = out_pixel_q;

	a_bits: assert property (@(posedge clk) disable iff (!arst_n) bc_q <= 5'd24)
		else $error("bit count above buffer size");
	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		cw_q >= 4'd3 && cw_q <= 4'(gifl_pkg::MaxCodeBits))
		else $error("code width out of range");
	a_free: assert property (@(posedge clk) disable iff (!arst_n) nf_q <= TableSize)
		else $error("next free entry beyond table");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gifl_pkg::S_EMIT && slot_free |=> out_valid_q)
		else $error("held result not delivered");
	a_stack: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= TableSize)
		else $error("stack count overflow");
endmodule
`default_nettype wire
